// File: design/resistive_touch_point_convert_core_assert.svh
// assertion helpers for the touch point converter
`ifndef RESISTIVE_TOUCH_POINT_CONVERT_CORE_ASSERT_SVH
`define RESISTIVE_TOUCH_POINT_CONVERT_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RTPC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtpc assertion failed");

// next-cycle implication, disabled while reset is low
`define RTPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtpc assertion failed");

`endif

// File: design/rtpc_pkg.sv
`timescale 1ns / 1ps

package rtpc_pkg;

    // adc and field widths
    localparam int ADC_BITS  = 10;
    localparam int SIZE_W    = 12;
    localparam int PLATE_W   = 16;
    localparam int ROT_W     = 2;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [ADC_BITS-1:0] ADC_MAX_V = {ADC_BITS{1'b1}};

    // pressure window and 16-bit signed limits
    localparam logic signed [OUT_W-1:0] PRESSURE_FLOOR = 16'sd10;
    localparam logic signed [OUT_W-1:0] PRESSURE_CEIL  = $signed({{(OUT_W-ADC_BITS){1'b0}},
                                                                  ADC_MAX_V});
    localparam logic signed [OUT_W-1:0] S16_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] S16_MIN = 16'sh8000;

    // shared divider geometry: quotients below 2^15, larger ones saturate
    localparam int DIV_STEPS = OUT_W - 1;
    localparam int DIV_DEN_W = ADC_BITS;
    localparam int DIV_NUM_W = ADC_BITS + PLATE_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_X_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLATE      = 3'd7;

    // rotation codes
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // per-item fields carried down the pipe
    typedef struct packed {
        logic                func;
        logic                eq;
        logic [ADC_BITS-1:0] rx;
        logic [ADC_BITS-1:0] ry;
        logic                dneg;
        logic [ADC_BITS-1:0] z1;
        logic                z2nz;
        logic [ADC_BITS+1:0] simple_p;
        logic                sxneg;
        logic                syneg;
    } item_t;

    // fields riding alongside the dividers
    typedef struct packed {
        item_t item;
        logic  psat;
        logic  sxsat;
        logic  sysat;
    } side_t;

    // saturate an 18-bit signed value to 16 bits
    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [OUT_W+1:0] v);
        logic signed [OUT_W-1:0] r;
        if ((v[OUT_W+1:OUT_W-1] == 3'b000) || (v[OUT_W+1:OUT_W-1] == 3'b111)) begin
            r = v[OUT_W-1:0];
        end else if (v[OUT_W+1]) begin
            r = S16_MIN;
        end else begin
            r = S16_MAX;
        end
        return r;
    endfunction

endpackage

// File: design/rtpc_div_pipe.sv
`timescale 1ns / 1ps

module rtpc_div_pipe import rtpc_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_STEPS-1:0] quot
);

    // partial remainders and divisors for all but the last step
    logic [DIV_NUM_W-1:0] rem_reg  [DIV_STEPS-1];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_STEPS-1];
    logic [DIV_STEPS-1:0] quot_reg [DIV_STEPS];

    // one restoring step per stage, msb of the quotient first
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        localparam int K = DIV_STEPS - 1 - i;

        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_STEPS-1:0] quot_in;
        logic [DIV_NUM_W-1:0] trial;
        logic                 fit;
        logic [DIV_STEPS-1:0] quot_next;

        if (i == 0) begin : g_first
            assign rem_in  = num;
            assign den_in  = den;
            assign quot_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quot_in = quot_reg[i-1];
        end

        assign trial     = DIV_NUM_W'(den_in) << K;
        assign fit       = (rem_in >= trial);
        assign quot_next = quot_in | (DIV_STEPS'(fit) << K);

        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[i] <= quot_next;
            end
        end

        if (i < DIV_STEPS - 1) begin : g_carry
            logic [DIV_NUM_W-1:0] rem_next;

            assign rem_next = fit ? (rem_in - trial) : rem_in;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
    end

    assign quot = quot_reg[DIV_STEPS-1];

endmodule

// File: design/resistive_touch_point_convert_core.sv
`timescale 1ns / 1ps
// Converts one 4-wire resistive panel measurement into a screen point.
// Input channel s_*: one item per measurement. s_tuser[0] is the filter flag;
// s_tdata holds the six 10-bit adc samples. Output channel m_*: one item with
// x, y and pressure, or none when the filter rejects the point.
// Configuration sits on the apb port, one register per word; write it only
// while no item is in flight. pready is always high.
// Throughput: one item per cycle while s_tready is high. The pipe runs through
// four front stages (sample prep, two multiplier stages, divider load), the
// fifteen one-bit stages of the pipelined dividers and two output stages (sign
// and saturation, rotation) into the output register that drives m_tvalid.
// Reset clears the configuration registers and valid bits to 0 and empties the pipe.
// When the receiver stalls, the output register holds its item and a skid
// register catches one more; only then does s_tready drop and the whole pipe
// hold in place, losing and repeating nothing.
`include "resistive_touch_point_convert_core_assert.svh"

module resistive_touch_point_convert_core import rtpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_sample_a, x_sample_b, y_sample_a, y_sample_b,
                                   // z1_sample, z2_sample, zero fill
    input  logic [0:0]  s_tuser,   // func
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // point_x, point_y, point_pressure
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [ROT_W-1:0]    cfg_rotation_reg;
    logic [SIZE_W-1:0]   cfg_width_reg;
    logic [SIZE_W-1:0]   cfg_height_reg;
    logic [ADC_BITS-1:0] cfg_cal_x_low_reg;
    logic [ADC_BITS-1:0] cfg_cal_x_high_reg;
    logic [ADC_BITS-1:0] cfg_cal_y_low_reg;
    logic [ADC_BITS-1:0] cfg_cal_y_high_reg;
    logic [PLATE_W-1:0]  cfg_plate_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rotation_reg   <= '0;
            cfg_width_reg      <= '0;
            cfg_height_reg     <= '0;
            cfg_cal_x_low_reg  <= '0;
            cfg_cal_x_high_reg <= '0;
            cfg_cal_y_low_reg  <= '0;
            cfg_cal_y_high_reg <= '0;
            cfg_plate_reg      <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ROTATION:   cfg_rotation_reg   <= pwdata[ROT_W-1:0];
                REG_WIDTH:      cfg_width_reg      <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:     cfg_height_reg     <= pwdata[SIZE_W-1:0];
                REG_CAL_X_LOW:  cfg_cal_x_low_reg  <= pwdata[ADC_BITS-1:0];
                REG_CAL_X_HIGH: cfg_cal_x_high_reg <= pwdata[ADC_BITS-1:0];
                REG_CAL_Y_LOW:  cfg_cal_y_low_reg  <= pwdata[ADC_BITS-1:0];
                REG_CAL_Y_HIGH: cfg_cal_y_high_reg <= pwdata[ADC_BITS-1:0];
                REG_PLATE:      cfg_plate_reg      <= pwdata[PLATE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_ROTATION:   prdata = 32'(cfg_rotation_reg);
            REG_WIDTH:      prdata = 32'(cfg_width_reg);
            REG_HEIGHT:     prdata = 32'(cfg_height_reg);
            REG_CAL_X_LOW:  prdata = 32'(cfg_cal_x_low_reg);
            REG_CAL_X_HIGH: prdata = 32'(cfg_cal_x_high_reg);
            REG_CAL_Y_LOW:  prdata = 32'(cfg_cal_y_low_reg);
            REG_CAL_Y_HIGH: prdata = 32'(cfg_cal_y_high_reg);
            REG_PLATE:      prdata = 32'(cfg_plate_reg);
            default:        prdata = '0;
        endcase
    end

    // calibration spans; the user keeps them static while items are in flight, the block does not enforce it
    logic signed [ADC_BITS:0] span_x;
    logic signed [ADC_BITS:0] span_y;
    logic        [ADC_BITS:0] span_x_inv;
    logic        [ADC_BITS:0] span_y_inv;
    logic [ADC_BITS-1:0]      span_x_mag;
    logic [ADC_BITS-1:0]      span_y_mag;
    logic                     span_x_zero;
    logic                     span_y_zero;
    logic                     scale_on;

    assign span_x      = $signed({1'b0, cfg_cal_x_high_reg}) - $signed({1'b0, cfg_cal_x_low_reg});
    assign span_y      = $signed({1'b0, cfg_cal_y_high_reg}) - $signed({1'b0, cfg_cal_y_low_reg});
    assign span_x_inv  = -span_x;
    assign span_y_inv  = -span_y;
    assign span_x_mag  = span_x[ADC_BITS] ? span_x_inv[ADC_BITS-1:0] : span_x[ADC_BITS-1:0];
    assign span_y_mag  = span_y[ADC_BITS] ? span_y_inv[ADC_BITS-1:0] : span_y[ADC_BITS-1:0];
    assign span_x_zero = (cfg_cal_x_high_reg == cfg_cal_x_low_reg);
    assign span_y_zero = (cfg_cal_y_high_reg == cfg_cal_y_low_reg);
    assign scale_on    = (cfg_width_reg != '0) && (cfg_height_reg != '0);

    // pipe advances whenever the skid slot is free
    logic adv;
    logic skid_valid_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // valid bits
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 s4_valid_reg;
    logic [DIV_STEPS-1:0] div_valid_reg;
    logic                 f1_valid_reg;
    logic                 f2_valid_reg;
    logic                 f1_keep_next;

    // stage 1: sample unpack, differences and magnitudes
    logic [ADC_BITS-1:0] in_xa, in_xb, in_ya, in_yb, in_z1, in_z2;
    logic [ADC_BITS:0]   in_d, in_d_inv, in_nx, in_nx_inv, in_ny, in_ny_inv;
    item_t               s1_item_next;
    logic [ADC_BITS-1:0] s1_dmag_next, s1_nxmag_next, s1_nymag_next;

    assign in_xa = s_tdata[0*ADC_BITS +: ADC_BITS];
    assign in_xb = s_tdata[1*ADC_BITS +: ADC_BITS];
    assign in_ya = s_tdata[2*ADC_BITS +: ADC_BITS];
    assign in_yb = s_tdata[3*ADC_BITS +: ADC_BITS];
    assign in_z1 = s_tdata[4*ADC_BITS +: ADC_BITS];
    assign in_z2 = s_tdata[5*ADC_BITS +: ADC_BITS];

    always_comb begin
        s1_item_next.func     = s_tuser[0];
        s1_item_next.eq       = (in_xa == in_xb) && (in_ya == in_yb);
        s1_item_next.rx       = ADC_MAX_V - in_xb;
        s1_item_next.ry       = ADC_MAX_V - in_yb;
        s1_item_next.z1       = in_z1;
        s1_item_next.z2nz     = (in_z2 != '0);
        s1_item_next.simple_p = (ADC_BITS+2)'(ADC_MAX_V - in_z2) + (ADC_BITS+2)'(in_z1);

        in_d     = {1'b0, in_z2} - {1'b0, in_z1};
        in_d_inv = -in_d;
        in_nx    = {1'b0, s1_item_next.rx} - {1'b0, cfg_cal_x_low_reg};
        in_nx_inv = -in_nx;
        in_ny    = {1'b0, s1_item_next.ry} - {1'b0, cfg_cal_y_low_reg};
        in_ny_inv = -in_ny;

        s1_item_next.dneg  = in_d[ADC_BITS];
        s1_item_next.sxneg = in_nx[ADC_BITS] ^ span_x[ADC_BITS];
        s1_item_next.syneg = in_ny[ADC_BITS] ^ span_y[ADC_BITS];

        s1_dmag_next  = in_d[ADC_BITS]  ? in_d_inv[ADC_BITS-1:0]  : in_d[ADC_BITS-1:0];
        s1_nxmag_next = in_nx[ADC_BITS] ? in_nx_inv[ADC_BITS-1:0] : in_nx[ADC_BITS-1:0];
        s1_nymag_next = in_ny[ADC_BITS] ? in_ny_inv[ADC_BITS-1:0] : in_ny[ADC_BITS-1:0];
    end

    item_t                      s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic [ADC_BITS-1:0]        s1_dmag_reg, s1_nxmag_reg, s1_nymag_reg;
    logic [2*ADC_BITS-1:0]      s2_pm1_reg;
    logic [ADC_BITS+SIZE_W-1:0] s2_sxn_reg, s2_syn_reg;
    logic [ADC_BITS+SIZE_W-1:0] s3_sxn_reg, s3_syn_reg;
    logic [ADC_BITS+SIZE_W-1:0] s4_sxn_reg, s4_syn_reg;
    logic [2*ADC_BITS+PLATE_W-1:0] s3_pmag_reg;
    logic [DIV_NUM_W-1:0]       s4_pnum_reg;

    // front stages: sample prep, two multiplies, then drop the adc scale for the divider
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= s1_item_next;
            s1_dmag_reg  <= s1_dmag_next;
            s1_nxmag_reg <= s1_nxmag_next;
            s1_nymag_reg <= s1_nymag_next;

            s2_item_reg <= s1_item_reg;
            s2_pm1_reg  <= (2*ADC_BITS)'(s1_dmag_reg) * (2*ADC_BITS)'(s1_item_reg.rx);
            s2_sxn_reg  <= (ADC_BITS+SIZE_W)'(s1_nxmag_reg) * (ADC_BITS+SIZE_W)'(cfg_width_reg);
            s2_syn_reg  <= (ADC_BITS+SIZE_W)'(s1_nymag_reg) * (ADC_BITS+SIZE_W)'(cfg_height_reg);

            s3_item_reg <= s2_item_reg;
            s3_pmag_reg <= (2*ADC_BITS+PLATE_W)'(s2_pm1_reg)
                         * (2*ADC_BITS+PLATE_W)'(cfg_plate_reg);
            s3_sxn_reg  <= s2_sxn_reg;
            s3_syn_reg  <= s2_syn_reg;

            s4_item_reg <= s3_item_reg;
            s4_pnum_reg <= s3_pmag_reg[2*ADC_BITS+PLATE_W-1:ADC_BITS];
            s4_sxn_reg  <= s3_sxn_reg;
            s4_syn_reg  <= s3_syn_reg;
        end
    end

    // divider entry: saturation checks against divisor shifted past the quotient
    side_t side_in;

    always_comb begin
        side_in.item  = s4_item_reg;
        side_in.psat  = s4_pnum_reg >= (DIV_NUM_W'(s4_item_reg.z1) << DIV_STEPS);
        side_in.sxsat = DIV_NUM_W'(s4_sxn_reg) >= (DIV_NUM_W'(span_x_mag) << DIV_STEPS);
        side_in.sysat = DIV_NUM_W'(s4_syn_reg) >= (DIV_NUM_W'(span_y_mag) << DIV_STEPS);
    end

    logic [DIV_STEPS-1:0] quot_p, quot_x, quot_y;

    rtpc_div_pipe u_div_p (
        .aclk (aclk),
        .en   (adv),
        .num  (s4_pnum_reg),
        .den  (s4_item_reg.z1),
        .quot (quot_p)
    );

    rtpc_div_pipe u_div_x (
        .aclk (aclk),
        .en   (adv),
        .num  (DIV_NUM_W'(s4_sxn_reg)),
        .den  (span_x_mag),
        .quot (quot_x)
    );

    rtpc_div_pipe u_div_y (
        .aclk (aclk),
        .en   (adv),
        .num  (DIV_NUM_W'(s4_syn_reg)),
        .den  (span_y_mag),
        .quot (quot_y)
    );

    // sideband delay line matching the divider depth
    side_t div_side_reg [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_side_reg[0] <= side_in;
            for (int i = 1; i < DIV_STEPS; i++) begin
                div_side_reg[i] <= div_side_reg[i-1];
            end
        end
    end

    // stage f1: signs, special cases, saturation and the pressure window
    side_t                   side_last;
    logic signed [OUT_W-1:0] f1_pz_next, f1_sx_next, f1_sy_next;
    logic signed [OUT_W-1:0] qp_s, qx_s, qy_s;

    assign side_last = div_side_reg[DIV_STEPS-1];
    assign qp_s      = $signed({1'b0, quot_p});
    assign qx_s      = $signed({1'b0, quot_x});
    assign qy_s      = $signed({1'b0, quot_y});

    always_comb begin
        if (!side_last.item.eq) begin
            f1_pz_next = '0;
        end else if (cfg_plate_reg == '0) begin
            f1_pz_next = $signed(OUT_W'(side_last.item.simple_p));
        end else if (side_last.item.z1 == '0) begin
            f1_pz_next = (side_last.item.z2nz && (side_last.item.rx != '0)) ? S16_MAX : '0;
        end else if (side_last.psat) begin
            f1_pz_next = side_last.item.dneg ? S16_MIN : S16_MAX;
        end else begin
            f1_pz_next = side_last.item.dneg ? -qp_s : qp_s;
        end

        if (span_x_zero) begin
            f1_sx_next = '0;
        end else if (side_last.sxsat) begin
            f1_sx_next = side_last.item.sxneg ? S16_MIN : S16_MAX;
        end else begin
            f1_sx_next = side_last.item.sxneg ? -qx_s : qx_s;
        end

        if (span_y_zero) begin
            f1_sy_next = '0;
        end else if (side_last.sysat) begin
            f1_sy_next = side_last.item.syneg ? S16_MIN : S16_MAX;
        end else begin
            f1_sy_next = side_last.item.syneg ? -qy_s : qy_s;
        end

        f1_keep_next = !side_last.item.func
                     || ((f1_pz_next > PRESSURE_FLOOR) && (f1_pz_next < PRESSURE_CEIL));
    end

    logic signed [OUT_W-1:0] f1_pz_reg, f1_sx_reg, f1_sy_reg;
    logic [ADC_BITS-1:0]     f1_rx_reg, f1_ry_reg;
    logic                    f1_eq_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_pz_reg <= f1_pz_next;
            f1_sx_reg <= f1_sx_next;
            f1_sy_reg <= f1_sy_next;
            f1_rx_reg <= side_last.item.rx;
            f1_ry_reg <= side_last.item.ry;
            f1_eq_reg <= side_last.item.eq;
        end
    end

    // stage f2: rotation against the portrait size, or the raw point when scaling is off
    logic signed [OUT_W+1:0] w_minus_sx, h_minus_sy;
    logic signed [OUT_W-1:0] px_next, py_next;
    logic [3*OUT_W-1:0]      f2_data_next;

    assign w_minus_sx = $signed({{(OUT_W+2-SIZE_W){1'b0}}, cfg_width_reg})
                      - $signed({{2{f1_sx_reg[OUT_W-1]}}, f1_sx_reg});
    assign h_minus_sy = $signed({{(OUT_W+2-SIZE_W){1'b0}}, cfg_height_reg})
                      - $signed({{2{f1_sy_reg[OUT_W-1]}}, f1_sy_reg});

    always_comb begin
        if (!scale_on) begin
            px_next = $signed(OUT_W'(f1_rx_reg));
            py_next = $signed(OUT_W'(f1_ry_reg));
        end else begin
            case (cfg_rotation_reg)
                ROT_0: begin
                    px_next = f1_sx_reg;
                    py_next = f1_sy_reg;
                end
                ROT_90: begin
                    px_next = f1_sy_reg;
                    py_next = sat16(w_minus_sx);
                end
                ROT_180: begin
                    px_next = sat16(w_minus_sx);
                    py_next = sat16(h_minus_sy);
                end
                ROT_270: begin
                    px_next = sat16(h_minus_sy);
                    py_next = f1_sx_reg;
                end
                default: begin
                    px_next = f1_sx_reg;
                    py_next = f1_sy_reg;
                end
            endcase
        end
        f2_data_next = {f1_pz_reg, py_next, px_next};
    end

    logic [3*OUT_W-1:0] f2_data_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            f2_data_reg <= f2_data_next;
        end
    end

    // valid bits, cleared by reset, dropped items leave a bubble
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-2:0], s4_valid_reg};
            f1_valid_reg  <= div_valid_reg[DIV_STEPS-1] && f1_keep_next;
            f2_valid_reg  <= f1_valid_reg;
        end
    end

    // output register with one skid entry
    logic               out_valid_reg;
    logic [3*OUT_W-1:0] out_data_reg;
    logic [3*OUT_W-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (f2_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (f2_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= f2_data_reg;
            end else begin
                skid_data_reg <= f2_data_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `RTPC_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `RTPC_ASSERT_NEXT(a_stall_holds_pipe, aclk, aresetn, skid_valid_reg, $stable(div_valid_reg) && $stable(f2_valid_reg))
    `RTPC_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_tready, !skid_valid_reg)
    `RTPC_ASSERT_IMPL(a_unequal_no_pressure, aclk, aresetn, f1_valid_reg && !f1_eq_reg, f1_pz_reg == '0)

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rtpc_pkg::*;

    localparam longint ADC_FULL      = (1 << ADC_BITS) - 1;
    localparam longint ADC_RANGE     = 1 << ADC_BITS;
    localparam longint SAT_HI        = 32767;
    localparam longint SAT_LO        = -32768;
    localparam int     PIPE_SETTLE   = 40;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_ITEMS   = 96;
    localparam int     HOLD_PHASE    = 2;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     NUM_DIRECTED  = 26;

    // fixed register setups used by the directed rows
    localparam int SETUP_RESET     = 0;
    localparam int SETUP_ROT0      = 1;
    localparam int SETUP_ROT90     = 2;
    localparam int SETUP_ROT180    = 3;
    localparam int SETUP_ROT270    = 4;
    localparam int SETUP_FLAT_SPAN = 5;
    localparam int SETUP_EXTREME   = 6;
    localparam int SETUP_NO_SCALE  = 7;

    typedef struct packed {
        logic                func;
        logic [ADC_BITS-1:0] xa;
        logic [ADC_BITS-1:0] xb;
        logic [ADC_BITS-1:0] ya;
        logic [ADC_BITS-1:0] yb;
        logic [ADC_BITS-1:0] z1;
        logic [ADC_BITS-1:0] z2;
    } touch_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic signed [OUT_W-1:0] pz;
    } touch_point_t;

    typedef struct packed {
        logic [ROT_W-1:0]    rot;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [ADC_BITS-1:0] xlo;
        logic [ADC_BITS-1:0] xhi;
        logic [ADC_BITS-1:0] ylo;
        logic [ADC_BITS-1:0] yhi;
        logic [PLATE_W-1:0]  plate;
    } panel_cfg_t;

    typedef struct packed {
        logic [3:0]   setup;
        touch_item_t  item;
        logic         typed;
        logic         emits;
        touch_point_t pt;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    touch_point_t expected_points[$];
    panel_cfg_t   panel_cfg;
    bit           no_gaps;
    bit           hold_request;
    int           items_sent;
    int           points_checked;
    int           points_dropped;
    int           mismatches;
    int           input_stalls;
    int           settings_used;

    // directed rows: setup, item, typed flag, emits, typed point
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        // reset setup: raw point and simple pressure, values read off directly
        '{SETUP_RESET, '{0, 0, 0, 0, 0, 0, 0}, 1, 1, '{1023, 1023, 1023}},
        '{SETUP_RESET, '{0, 1023, 1023, 1023, 1023, 1023, 1023}, 1, 1, '{0, 0, 1023}},
        '{SETUP_RESET, '{0, 5, 6, 100, 100, 200, 300}, 1, 1, '{1017, 923, 0}},
        '{SETUP_RESET, '{1, 5, 6, 100, 100, 200, 300}, 1, 0, '{0, 0, 0}},
        '{SETUP_RESET, '{0, 0, 0, 7, 8, 0, 0}, 1, 1, '{1023, 1015, 0}},
        '{SETUP_RESET, '{0, 512, 512, 256, 256, 0, 1023}, 1, 1, '{511, 767, 0}},
        '{SETUP_RESET, '{1, 1, 1, 1, 1, 1023, 0}, 1, 0, '{0, 0, 0}},
        '{SETUP_RESET, '{0, 1, 1, 1, 1, 1023, 0}, 1, 1, '{1022, 1022, 2046}},
        '{SETUP_RESET, '{1, 682, 682, 341, 341, 300, 600}, 1, 1, '{341, 682, 723}},
        // pressure window edges
        '{SETUP_RESET, '{1, 10, 10, 20, 20, 5, 1018}, 1, 0, '{0, 0, 0}},
        '{SETUP_RESET, '{1, 10, 10, 20, 20, 5, 1017}, 1, 1, '{1013, 1003, 11}},
        '{SETUP_RESET, '{1, 10, 10, 20, 20, 5, 6}, 1, 1, '{1013, 1003, 1022}},
        '{SETUP_RESET, '{1, 10, 10, 20, 20, 6, 6}, 1, 0, '{0, 0, 0}},
        // plate pressure, zero z1 cases, negative pressure
        '{SETUP_ROT0, '{0, 300, 300, 400, 400, 0, 500}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT0, '{0, 300, 300, 400, 400, 0, 0}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT0, '{0, 1023, 1023, 400, 400, 0, 500}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT0, '{0, 300, 300, 400, 400, 200, 700}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT0, '{1, 300, 300, 400, 400, 700, 200}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT0, '{0, 300, 300, 400, 400, 700, 200}, 0, 0, '{0, 0, 0}},
        // each rotation
        '{SETUP_ROT90, '{0, 200, 200, 600, 600, 100, 400}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT180, '{0, 200, 200, 600, 600, 100, 400}, 0, 0, '{0, 0, 0}},
        '{SETUP_ROT270, '{0, 200, 200, 600, 600, 100, 400}, 0, 0, '{0, 0, 0}},
        // zero calibration span and reversed span
        '{SETUP_FLAT_SPAN, '{0, 333, 333, 444, 444, 50, 600}, 0, 0, '{0, 0, 0}},
        // saturation both ways
        '{SETUP_EXTREME, '{0, 0, 0, 1023, 1023, 1, 1023}, 0, 0, '{0, 0, 0}},
        '{SETUP_EXTREME, '{0, 0, 0, 0, 0, 1023, 0}, 0, 0, '{0, 0, 0}},
        // one size zero turns scaling off
        '{SETUP_NO_SCALE, '{1, 400, 400, 500, 500, 100, 200}, 0, 0, '{0, 0, 0}}
    };

    resistive_touch_point_convert_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint clamp_s16(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint scale_to_screen(input longint raw, input longint lo,
                                               input longint hi, input longint size);
        longint span;
        span = hi - lo;
        if (span == 0) return 0;
        return clamp_s16(((raw - lo) * size) / span);
    endfunction

    // expected point for one measurement, returns 0 when the filter drops it
    function automatic bit predict_point(input touch_item_t it, output touch_point_t pt);
        longint xb, yb, z1, z2, rx, ry, pz, sx, sy, px, py, w, h, plate;
        xb = longint'(it.xb);
        yb = longint'(it.yb);
        z1 = longint'(it.z1);
        z2 = longint'(it.z2);
        rx = ADC_FULL - xb;
        ry = ADC_FULL - yb;
        plate = longint'(panel_cfg.plate);
        w = longint'(panel_cfg.width);
        h = longint'(panel_cfg.height);
        pt = '0;

        // pressure
        if (plate != 0) begin
            if (z1 == 0) begin
                pz = (z2 != 0 && rx != 0) ? SAT_HI : 0;
            end else begin
                pz = clamp_s16(((z2 - z1) * rx * plate) / (z1 * ADC_RANGE));
            end
        end else begin
            pz = clamp_s16(ADC_FULL - (z2 - z1));
        end
        if (it.xa != it.xb || it.ya != it.yb) pz = 0;

        // pressure window in filtered mode
        if (it.func && !(pz > longint'(PRESSURE_FLOOR) && pz < ADC_FULL)) return 0;

        // scaling and rotation
        if (w != 0 && h != 0) begin
            sx = scale_to_screen(rx, longint'(panel_cfg.xlo), longint'(panel_cfg.xhi), w);
            sy = scale_to_screen(ry, longint'(panel_cfg.ylo), longint'(panel_cfg.yhi), h);
            case (panel_cfg.rot)
                ROT_90: begin
                    px = sy;
                    py = w - sx;
                end
                ROT_180: begin
                    px = w - sx;
                    py = h - sy;
                end
                ROT_270: begin
                    px = h - sy;
                    py = sx;
                end
                default: begin
                    px = sx;
                    py = sy;
                end
            endcase
            px = clamp_s16(px);
            py = clamp_s16(py);
        end else begin
            px = rx;
            py = ry;
        end
        pt.px = px[OUT_W-1:0];
        pt.py = py[OUT_W-1:0];
        pt.pz = pz[OUT_W-1:0];
        return 1;
    endfunction

    function automatic panel_cfg_t setup_cfg(input int sel);
        panel_cfg_t c;
        c = '0;
        case (sel)
            SETUP_ROT0, SETUP_ROT90, SETUP_ROT180, SETUP_ROT270: begin
                c.rot = (sel == SETUP_ROT90) ? ROT_90 :
                        (sel == SETUP_ROT180) ? ROT_180 :
                        (sel == SETUP_ROT270) ? ROT_270 : ROT_0;
                c.width = 240;
                c.height = 320;
                c.xlo = 100;
                c.xhi = 900;
                c.ylo = 150;
                c.yhi = 950;
                c.plate = 400;
            end
            SETUP_FLAT_SPAN: begin
                c.rot = ROT_0;
                c.width = 1;
                c.height = 4095;
                c.xlo = 500;
                c.xhi = 500;
                c.ylo = 900;
                c.yhi = 100;
                c.plate = 65535;
            end
            SETUP_EXTREME: begin
                c.rot = ROT_270;
                c.width = 4095;
                c.height = 4095;
                c.xlo = 0;
                c.xhi = 1;
                c.ylo = 1023;
                c.yhi = 0;
                c.plate = 65535;
            end
            SETUP_NO_SCALE: begin
                c.rot = ROT_180;
                c.width = 100;
                c.height = 0;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic panel_cfg_t random_cfg();
        panel_cfg_t c;
        c.rot = ROT_W'($urandom_range(0, 3));
        c.width = ($urandom_range(0, 5) == 0) ? '0 : SIZE_W'($urandom_range(1, 4095));
        c.height = ($urandom_range(0, 5) == 0) ? '0 : SIZE_W'($urandom_range(1, 4095));
        // x calibration: a sane span half the time, else flat or arbitrary
        case ($urandom_range(0, 5))
            0: begin
                c.xlo = 10'($urandom_range(0, 1023));
                c.xhi = c.xlo;
            end
            1, 2: begin
                c.xlo = 10'($urandom_range(0, 1023));
                c.xhi = 10'($urandom_range(0, 1023));
            end
            default: begin
                c.xlo = 10'($urandom_range(0, 200));
                c.xhi = 10'($urandom_range(800, 1023));
            end
        endcase
        case ($urandom_range(0, 5))
            0: begin
                c.ylo = 10'($urandom_range(0, 1023));
                c.yhi = c.ylo;
            end
            1, 2: begin
                c.ylo = 10'($urandom_range(0, 1023));
                c.yhi = 10'($urandom_range(0, 1023));
            end
            default: begin
                c.ylo = 10'($urandom_range(0, 200));
                c.yhi = 10'($urandom_range(800, 1023));
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1: c.plate = '0;
            2: c.plate = 16'hffff;
            3, 4, 5: c.plate = PLATE_W'($urandom_range(100, 1000));
            default: c.plate = PLATE_W'($urandom_range(1, 65535));
        endcase
        return c;
    endfunction

    // mostly consistent measurements, some with disagreeing sample pairs
    function automatic touch_item_t random_item();
        touch_item_t it;
        it.func = 1'($urandom_range(0, 1));
        it.xa = 10'($urandom_range(0, 1023));
        it.ya = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 7) begin
            it.xb = it.xa;
            it.yb = it.ya;
        end else if ($urandom_range(0, 1) == 0) begin
            it.xb = it.xa ^ (10'd1 << $urandom_range(0, ADC_BITS - 1));
            it.yb = ($urandom_range(0, 1) == 0) ? it.ya : 10'($urandom_range(0, 1023));
        end else begin
            it.xb = ($urandom_range(0, 1) == 0) ? it.xa : 10'($urandom_range(0, 1023));
            it.yb = it.ya ^ (10'd1 << $urandom_range(0, ADC_BITS - 1));
        end
        it.z1 = 10'($urandom_range(0, 1023));
        it.z2 = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0: it.z1 = '0;
            1: it.z2 = '0;
            2: it.z2 = it.z1;
            3: it.z2 = 10'(1023);
            4, 5: begin
                it.z1 = 10'($urandom_range(50, 600));
                it.z2 = it.z1 + 10'($urandom_range(1, 400));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic apb_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
    endtask

    // write every register, then release the bus
    task automatic apply_cfg(input panel_cfg_t c);
        apb_write(REG_ROTATION, 32'(c.rot));
        apb_write(REG_WIDTH, 32'(c.width));
        apb_write(REG_HEIGHT, 32'(c.height));
        apb_write(REG_CAL_X_LOW, 32'(c.xlo));
        apb_write(REG_CAL_X_HIGH, 32'(c.xhi));
        apb_write(REG_CAL_Y_LOW, 32'(c.ylo));
        apb_write(REG_CAL_Y_HIGH, 32'(c.yhi));
        apb_write(REG_PLATE, 32'(c.plate));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        panel_cfg = c;
        settings_used++;
        @(negedge aclk);
    endtask

    // wait for all outstanding points, then let dropped items leave the pipe
    task automatic settle();
        int n;
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && expected_points.size() > 0; n++) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic send_item(input touch_item_t it, input bit use_given,
                             input bit given_emit, input touch_point_t given_pt);
        touch_point_t pt;
        bit           emit;
        int           gap;
        if (use_given) begin
            emit = given_emit;
            pt = given_pt;
        end else begin
            emit = predict_point(it, pt);
        end
        // optional gap before the item
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.func;
        s_tdata <= {4'b0, it.z2, it.z1, it.yb, it.ya, it.xb, it.xa};
        do @(posedge aclk); while (!s_tready);
        if (emit) begin
            expected_points.push_back(pt);
        end else begin
            points_dropped++;
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // result sink with random stalls and one long hold-off on request
    initial begin : point_sink
        int stall_left;
        int mode_left;
        bit steady;
        stall_left = 0;
        mode_left = 0;
        steady = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (aresetn && !steady && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                         : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each accepted point with the oldest expected one
    always @(posedge aclk) begin : point_check
        touch_point_t got;
        touch_point_t want;
        if (aresetn) begin
            if (s_tvalid && !s_tready) input_stalls++;
            if (m_tvalid && m_tready) begin
                got.px = m_tdata[15:0];
                got.py = m_tdata[31:16];
                got.pz = m_tdata[47:32];
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected point x=%0d y=%0d p=%0d", got.px, got.py, got.pz);
                    end
                end else begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("point mismatch: expected x=%0d y=%0d p=%0d, got x=%0d y=%0d p=%0d",
                                     want.px, want.py, want.pz, got.px, got.py, got.pz);
                        end
                    end
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int i;
        int phase;
        int cur_setup;
        panel_cfg_t c;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        panel_cfg = '0;
        no_gaps = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        points_checked = 0;
        points_dropped = 0;
        mismatches = 0;
        input_stalls = 0;
        settings_used = 1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(negedge aclk);

        // directed rows, switching register setup where a row asks for it
        cur_setup = SETUP_RESET;
        for (i = 0; i < NUM_DIRECTED; i++) begin
            if (int'(directed_rows[i].setup) != cur_setup) begin
                settle();
                cur_setup = int'(directed_rows[i].setup);
                apply_cfg(setup_cfg(cur_setup));
            end
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].emits, directed_rows[i].pt);
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            if (phase == 0) begin
                c = '0;
            end else if (phase == 1) begin
                c = '1;
            end else begin
                c = random_cfg();
            end
            apply_cfg(c);
            no_gaps = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE) hold_request = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_item(), 0, 0, '0);
            end
        end
        settle();

        $display("covered %0d items over %0d register settings: %0d points checked, %0d filtered",
                 items_sent, settings_used, points_checked, points_dropped);
        $display("input held back for %0d cycles, %0d points left unmatched, %0d mismatches",
                 input_stalls, expected_points.size(), mismatches);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
